// ===== rtl/gnmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnmc_pkg - shared types and constants of the neighbor mark counter
// Register map, request codes and the job word that travels from the
// front end through the queue to the result sequencer.
// ----------------------------------------------------------------------------
package gnmc_pkg;

	localparam int DEF_MAX_COLS    = 1024;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 16;
	localparam int COUNT_W  = 4;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;
	localparam int WIN_W    = 9;

	typedef enum logic {
		REQ_CELL  = 1'b0,
		REQ_DRAIN = 1'b1
	} req_type_t;

	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_index_t;

	// window bit rr*3+cc: rr 0 top .. 2 bottom, cc 0 oldest .. 2 newest column
	typedef struct packed {
		logic [WIN_W-1:0] win;
		logic             top_en;
		logic             bot_en;
		logic             emit_a;
		logic             left_a;
		logic             right_a;
		logic             end_a;
		logic             last_a;
		logic             emit_b;
		logic             left_b;
	} job_t;

endpackage

// ===== rtl/gnmc_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnmc_ifs - stream channels of the neighbor mark counter
// Valid/ready channels for incoming cell words and outgoing result words.
// ----------------------------------------------------------------------------
interface gnmc_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic cell_marked;

	modport source (output valid, output req_type, output cell_marked, input ready);
	modport sink (input valid, input req_type, input cell_marked, output ready);
endinterface

interface gnmc_out_if;
	logic                         valid;
	logic                         ready;
	logic                         out_marked;
	logic [gnmc_pkg::COUNT_W-1:0] neighbor_count;
	logic                         row_end;
	logic                         frame_end;
	logic                         last_of_run;

	modport source (output valid, output out_marked, output neighbor_count,
		output row_end, output frame_end, output last_of_run, input ready);
	modport sink (input valid, input out_marked, input neighbor_count,
		input row_end, input frame_end, input last_of_run, output ready);
endinterface

// ===== rtl/gnmc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnmc_front - raster tracking, line buffers and 3x3 window
// Accepts cell and drain words, keeps the two previous rows in a 2-bit wide
// line buffer with a prefetched read, shifts the window and issues jobs.
// ----------------------------------------------------------------------------
module gnmc_front #(
	parameter int MAX_COLS = gnmc_pkg::DEF_MAX_COLS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	gnmc_in_if.sink                       cells,
	input  logic [gnmc_pkg::WIDTH_W-1:0]  grid_width,
	input  logic [gnmc_pkg::HEIGHT_W-1:0] grid_height,
	input  logic                          restart,
	input  logic                          queue_full,
	output logic                          push,
	output gnmc_pkg::job_t                job
);

	localparam int COL_W = $clog2(MAX_COLS);
	localparam int CNT_W = $clog2(MAX_COLS + 1);
	localparam int HW    = gnmc_pkg::HEIGHT_W;

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_PRIME = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic [COL_W-1:0]          col_q, col_d, drain_q, drain_d, raddr;
	logic [HW-1:0]             row_q, row_d, h_eff;
	logic [CNT_W-1:0]          w_eff, col_p1, drain_p1;
	logic [gnmc_pkg::WIN_W-1:0] win_q, win_d, win_sh;
	logic [1:0]                rd_q;        // {row two above, row above}
	logic [1:0]                mem_q [MAX_COLS];
	logic [1:0]                wdata;
	logic                      mem_we, acc, is_cell, is_drain;
	logic                      row_last, frame_last, drain_last;
	logic                      top_new, mid_new, bot_new;

	always_comb begin
		if (grid_width == '0) begin
			w_eff = CNT_W'(1);
		end else if (32'(grid_width) > 32'(MAX_COLS)) begin
			w_eff = CNT_W'(MAX_COLS);
		end else begin
			w_eff = CNT_W'(grid_width);
		end
	end

	assign h_eff = (grid_height == '0) ? HW'(1) : grid_height;

	assign cells.ready = (state_q != ST_PRIME) && !queue_full;
	assign acc         = cells.valid && cells.ready;
	assign is_cell     = acc && (cells.req_type == gnmc_pkg::REQ_CELL);
	assign is_drain    = acc && (cells.req_type == gnmc_pkg::REQ_DRAIN);

	assign col_p1     = CNT_W'(col_q) + CNT_W'(1);
	assign row_last   = col_p1 >= w_eff;
	assign frame_last = row_last && (row_q == h_eff - HW'(1));
	assign drain_p1   = CNT_W'(drain_q) + CNT_W'(1);
	assign drain_last = drain_p1 >= w_eff;

	always_comb begin
		if (state_q == ST_RUN) begin
			top_new = (row_q > HW'(1)) && rd_q[1];
			mid_new = (row_q != '0) && rd_q[0];
			bot_new = cells.cell_marked;
		end else begin
			top_new = rd_q[1];
			mid_new = rd_q[0];
			bot_new = 1'b0;
		end
	end

	assign win_sh = {bot_new, win_q[8:7], mid_new, win_q[5:4], top_new, win_q[2:1]};
	assign wdata  = {mid_new, cells.cell_marked};

	always_comb begin
		job.win = win_sh;
		if (state_q == ST_DRAIN) begin
			job.top_en  = h_eff > HW'(1);
			job.bot_en  = 1'b0;
			job.emit_a  = 1'b1;
			job.left_a  = drain_q != '0;
			job.right_a = !drain_last;
			job.end_a   = drain_last;
			job.last_a  = 1'b1;
			job.emit_b  = 1'b0;
			job.left_b  = 1'b0;
		end else begin
			job.top_en  = row_q > HW'(1);
			job.bot_en  = 1'b1;
			job.emit_a  = (row_q != '0) && (col_q != '0);
			job.left_a  = CNT_W'(col_q) >= CNT_W'(2);
			job.right_a = 1'b1;
			job.end_a   = 1'b0;
			job.last_a  = !row_last;
			job.emit_b  = (row_q != '0) && row_last;
			job.left_b  = w_eff != CNT_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		col_d   = col_q;
		row_d   = row_q;
		drain_d = drain_q;
		win_d   = win_q;
		push    = 1'b0;
		mem_we  = 1'b0;
		if (restart) begin
			state_d = ST_RUN;
			col_d   = '0;
			row_d   = '0;
			drain_d = '0;
			win_d   = '0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (is_cell) begin
						win_d  = win_sh;
						mem_we = 1'b1;
						push   = job.emit_a || job.emit_b;
						if (row_last) begin
							col_d   = '0;
							drain_d = '0;
							if (frame_last) begin
								state_d = ST_PRIME;
							end else begin
								row_d = row_q + HW'(1);
							end
						end else begin
							col_d = col_q + COL_W'(1);
						end
					end
				end
				ST_PRIME: begin
					win_d   = win_sh;
					drain_d = '0;
					state_d = ST_DRAIN;
				end
				ST_DRAIN: begin
					if (is_drain) begin
						push = 1'b1;
						if (drain_last) begin
							state_d = ST_RUN;
							col_d   = '0;
							row_d   = '0;
							drain_d = '0;
							win_d   = '0;
						end else begin
							win_d   = win_sh;
							drain_d = drain_q + COL_W'(1);
						end
					end
				end
				default: begin
					state_d = ST_RUN;
				end
			endcase
		end
	end

	// read the column the next word will need
	assign raddr = (state_d == ST_DRAIN) ? drain_d + COL_W'(1) : col_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
			win_q   <= '0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			drain_q <= drain_d;
			win_q   <= win_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[col_q] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && (col_q == raddr)) begin
			rd_q <= wdata;
		end else begin
			rd_q <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/gnmc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnmc_queue - job queue between front end and result sequencer
// Small register FIFO so either side can stall on its own.
// ----------------------------------------------------------------------------
module gnmc_queue #(
	parameter int DEPTH = gnmc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gnmc_pkg::job_t push_data,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output gnmc_pkg::job_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	gnmc_pkg::job_t   data_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full       = cnt_q == CNT_W'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = data_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/gnmc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnmc_back - neighbor count and result sequencer
// Counts marked neighbors for up to two cells per job and sends them out
// through a registered output word.
// ----------------------------------------------------------------------------
module gnmc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  gnmc_pkg::job_t head,
	output logic           pop,
	gnmc_out_if.source     results
);

	localparam int CW = gnmc_pkg::COUNT_W;

	logic          valid_q, phase_q;
	logic          marked_q, row_end_q, frame_end_q, last_q;
	logic [CW-1:0] count_q;
	logic          sel_b, load;
	logic [7:0]    nb_a, nb_b;
	logic          marked;
	logic [CW-1:0] count;
	logic [8:0]    w;

	function automatic logic [CW-1:0] ones8(input logic [7:0] v);
		logic [CW-1:0] s;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + CW'(v[i]);
		end
		return s;
	endfunction

	assign w     = head.win;
	assign sel_b = phase_q || !head.emit_a;
	assign load  = head_valid && (!valid_q || results.ready);
	assign pop   = load && (sel_b || !head.emit_b);

	// center in the middle column
	assign nb_a = {
		head.top_en & head.left_a & w[0], head.top_en & w[1],
		head.top_en & head.right_a & w[2],
		head.left_a & w[3], head.right_a & w[5],
		head.bot_en & head.left_a & w[6], head.bot_en & w[7],
		head.bot_en & head.right_a & w[8]
	};

	// center in the newest column, right edge of the row
	assign nb_b = {
		head.top_en & head.left_b & w[1], head.top_en & w[2],
		head.left_b & w[4],
		head.bot_en & head.left_b & w[7], head.bot_en & w[8],
		3'b000
	};

	always_comb begin
		marked = sel_b ? w[5] : w[4];
		count  = marked ? '0 : ones8(sel_b ? nb_b : nb_a);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= !sel_b && head.emit_b;
			end else if (results.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			marked_q    <= marked;
			count_q     <= count;
			row_end_q   <= sel_b || head.end_a;
			frame_end_q <= !sel_b && head.end_a;
			last_q      <= sel_b || head.last_a;
		end
	end

	assign results.valid          = valid_q;
	assign results.out_marked     = marked_q;
	assign results.neighbor_count = count_q;
	assign results.row_end        = row_end_q;
	assign results.frame_end      = frame_end_q;
	assign results.last_of_run    = last_q;

endmodule

// ===== rtl/grid_eight_neighbor_mark_count_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_eight_neighbor_mark_count_top - eight-neighbor mark counter
// Streams a binary grid in raster order and reports per cell its mark and, if
// unmarked, the number of marked neighbors. APB registers set the grid size.
// ----------------------------------------------------------------------------
// Cells enter one per clock while the job queue has room. Results lag by one
// row: a cell of row r reports the cell above and to its left, and the last
// cell of a row also reports the last cell of the row above, so one job gives
// two results; the job queue between the line-buffer front end and the result
// sequencer absorbs that. After a frame's last cell the input pauses while the
// line buffer read for the drain is primed; then one drain word per clock, while
// the queue has room, sends out the last row, and the last drain word ends the
// frame. Results pass the job queue and the registered output word. Writing a
// register restarts the frame. The line buffer needs no clearing after reset.
// ----------------------------------------------------------------------------
module grid_eight_neighbor_mark_count_top #(
	parameter int MAX_COLS    = gnmc_pkg::DEF_MAX_COLS,
	parameter int QUEUE_DEPTH = gnmc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	gnmc_in_if.sink                       cells,
	gnmc_out_if.source                    results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gnmc_pkg::ADDR_W-1:0]   paddr,
	input  logic [gnmc_pkg::DATA_W-1:0]   pwdata,
	output logic [gnmc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [gnmc_pkg::WIDTH_W-1:0]  width_q;
	logic [gnmc_pkg::HEIGHT_W-1:0] height_q;
	gnmc_pkg::reg_index_t          reg_idx;
	logic                          cfg_wr, push, full, head_valid, pop;
	gnmc_pkg::job_t                push_job, head_job;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = gnmc_pkg::reg_index_t'(paddr[gnmc_pkg::ADDR_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gnmc_pkg::WIDTH_W'(1);
			height_q <= gnmc_pkg::HEIGHT_W'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				gnmc_pkg::REG_GRID_WIDTH:  width_q  <= pwdata[gnmc_pkg::WIDTH_W-1:0];
				gnmc_pkg::REG_GRID_HEIGHT: height_q <= pwdata[gnmc_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			gnmc_pkg::REG_GRID_WIDTH:  prdata = gnmc_pkg::DATA_W'(width_q);
			gnmc_pkg::REG_GRID_HEIGHT: prdata = gnmc_pkg::DATA_W'(height_q);
			default:                   prdata = '0;
		endcase
	end

	gnmc_front #(
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cells      (cells),
		.grid_width (width_q),
		.grid_height(height_q),
		.restart    (cfg_wr),
		.queue_full (full),
		.push       (push),
		.job        (push_job)
	);

	gnmc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.full      (full),
		.head_valid(head_valid),
		.head      (head_job)
	);

	gnmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head_job),
		.pop       (pop),
		.results   (results)
	);

endmodule
